FILE: rtl/core/lne_pkg.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: shared package
// Types, register indexes, constants and table helpers.
// ----------------------------------------------------------------------------
package lne_pkg;

  localparam int NUM_CELLS_DEF   = 64;
  localparam int DECAY_BITS_DEF  = 8;
  localparam int CELL_W          = 6;
  localparam int MAX_CELLS       = 1 << CELL_W;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef enum logic [2:0] {
    REG_INV_TAU   = 3'd0,
    REG_INV_CAP   = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_RESET_V   = 3'd3,
    REG_REFRACT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        inv_tau;
    logic [23:0]        inv_cap;
    logic signed [31:0] threshold;
    logic signed [31:0] reset_v;
    logic [15:0]        refract;
  } cfg_t;

  typedef struct packed {
    logic               in_range;
    logic [CELL_W-1:0]  cidx;
    logic [31:0]        t;
    logic signed [23:0] w;
  } item_t;

  // floor integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    n   = n_in;
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/lne_if.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: channel interfaces
// Valid/ready channels for events and results.
// ----------------------------------------------------------------------------
interface lne_evt_if;
  logic               valid;
  logic               ready;
  logic [5:0]         cell_index;
  logic [31:0]        arrival_time;
  logic signed [23:0] synapse_weight;
  modport source (output valid, cell_index, arrival_time, synapse_weight, input ready);
  modport sink   (input valid, cell_index, arrival_time, synapse_weight, output ready);
endinterface

interface lne_res_if;
  logic               valid;
  logic               ready;
  logic               spiked;
  logic               accepted;
  logic [5:0]         spike_cell;
  logic [31:0]        spike_time;
  logic signed [31:0] membrane_voltage;
  modport source (output valid, spiked, accepted, spike_cell, spike_time,
                  membrane_voltage, input ready);
  modport sink   (input valid, spiked, accepted, spike_cell, spike_time,
                  membrane_voltage, output ready);
endinterface

FILE: rtl/core/lne_front.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: front end
// Takes events, flags out-of-range cells, hands items to the queue.
// ----------------------------------------------------------------------------
module lne_front #(
  parameter int NUM_CELLS = lne_pkg::NUM_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  lne_evt_if.sink         evt,
  output lne_pkg::item_t  q_data,
  output logic            q_valid,
  input  logic            q_ready
);
  import lne_pkg::*;

  item_t held;
  logic  held_v;

  assign evt.ready = !held_v || q_ready;
  assign q_valid   = held_v;
  assign q_data    = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_v <= 1'b0;
    end else if (evt.ready) begin
      held_v <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      held.in_range <= 32'(evt.cell_index) < NUM_CELLS;
      held.cidx     <= evt.cell_index;
      held.t        <= evt.arrival_time;
      held.w        <= evt.synapse_weight;
    end
  end

endmodule

FILE: rtl/core/lne_queue.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: item queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module lne_queue (
  input  logic           clk,
  input  logic           rst,
  input  lne_pkg::item_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output lne_pkg::item_t rd_data,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import lne_pkg::*;

  item_t       slots [2];
  logic        wp;
  logic        rp;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wr_data;
  end

endmodule

FILE: rtl/core/lne_back.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: back end
// Per-cell state, decay, weight scaling, threshold and result register.
// ----------------------------------------------------------------------------
module lne_back #(
  parameter int NUM_CELLS  = lne_pkg::NUM_CELLS_DEF,
  parameter int DECAY_BITS = lne_pkg::DECAY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lne_pkg::cfg_t  cfg,
  input  lne_pkg::item_t q_data,
  input  logic           q_valid,
  output logic           q_ready,
  lne_res_if.source      res
);
  import lne_pkg::*;

  localparam int DEPTH = (NUM_CELLS < MAX_CELLS) ? NUM_CELLS : MAX_CELLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TSIZE = (1 << DECAY_BITS) + 1;
  localparam int RW    = 24 - DECAY_BITS;

  typedef logic [31:0] dtab_t [TSIZE];

  function automatic dtab_t build_table();
    dtab_t       tab;
    logic [63:0] roots [DECAY_BITS];
    logic [63:0] v;
    logic [63:0] acc;
    v = 64'd1 << 30;
    for (int k = 0; k < DECAY_BITS; k++) begin
      v        = isqrt64(v << 31);
      roots[k] = v;
    end
    for (int i = 0; i < TSIZE - 1; i++) begin
      acc = 64'd1 << 31;
      for (int j = 0; j < DECAY_BITS; j++) begin
        if (((i >> j) & 1) != 0) begin
          acc = (acc * roots[DECAY_BITS - 1 - j] + (64'd1 << 30)) >> 31;
        end
      end
      tab[i] = acc[31:0];
    end
    tab[TSIZE-1] = 32'h4000_0000;
    return tab;
  endfunction

  localparam dtab_t DTAB = build_table();

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL1   = 6'b000010,
    S_MUL2   = 6'b000100,
    S_INTERP = 6'b001000,
    S_SCALE  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // cell state memory
  logic signed [31:0] vmem [DEPTH];
  logic [31:0]        tmem [DEPTH];
  logic [DEPTH-1:0]   cell_ok;
  logic signed [31:0] rd_v;
  logic [31:0]        rd_t;
  logic               rd_ok;

  item_t              it;
  logic signed [31:0] cur_v;
  logic               t_ok;
  logic               x_big;
  logic [29:0]        x_lo;
  logic               w_neg;
  logic [46:0]        pw;
  logic [30:0]        y;
  logic [31:0]        a_r;
  logic [32+RW-1:0]   dprod;
  logic [6:0]         n_r;
  logic               v_neg;
  logic [63:0]        vprod;

  logic               out_v;
  logic               out_spk;
  logic               out_acc;
  logic [CELL_W-1:0]  out_cell;
  logic [31:0]        out_t;
  logic signed [31:0] out_volt;

  // combinational step values
  logic [31:0]        last_t;
  logic [31:0]        elapsed;
  logic [47:0]        xw;
  logic [23:0]        w_mag;
  logic [60:0]        yp;
  logic [DECAY_BITS-1:0] idx;
  logic [DECAY_BITS:0]   idx1;
  logic [RW-1:0]      rem;
  logic [31:0]        ta;
  logic [31:0]        tb;
  logic [31:0]        d;
  logic [31:0]        fac;
  logic [31:0]        v_mag;
  logic [32:0]        pv;
  logic [30:0]        pwr;
  logic signed [34:0] sum;
  logic signed [31:0] vsat;
  logic               spike;
  logic [32:0]        t_sum;
  logic               fin_go;
  logic               do_wr;

  always_comb begin
    last_t  = rd_ok ? rd_t : 32'd0;
    elapsed = it.t - last_t;
    xw      = 48'(elapsed) * 48'(cfg.inv_tau);
    w_mag   = it.w[23] ? 24'(-it.w) : 24'(it.w);
    yp      = 61'(x_lo) * 61'(LOG2E_Q30);
    idx     = y[23 -: DECAY_BITS];
    idx1    = (DECAY_BITS+1)'(idx) + 1'b1;
    rem     = y[RW-1:0];
    ta      = DTAB[idx];
    tb      = DTAB[idx1];
    d       = a_r - 32'(dprod >> RW);
    fac     = (x_big || n_r >= 7'd32) ? 32'd0 : d >> n_r[4:0];
    v_mag   = cur_v[31] ? 32'(-cur_v) : 32'(cur_v);
    pv      = 33'((vprod + (64'd1 << 30)) >> 31);
    pwr     = 31'((pw + (47'd1 << 15)) >> 16);
    sum     = (v_neg ? -35'(pv) : 35'(pv)) + (w_neg ? -35'(pwr) : 35'(pwr));
    if (sum > 35'sd2147483647)       vsat = 32'sh7fff_ffff;
    else if (sum < -35'sd2147483648) vsat = 32'sh8000_0000;
    else                             vsat = 32'(sum);
    spike   = vsat >= cfg.threshold;
    t_sum   = 33'(it.t) + 33'(cfg.refract);
    fin_go  = !out_v || res.ready;
    do_wr   = (state == S_FIN) && fin_go && it.in_range && t_ok;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (q_valid) state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_INTERP;
      S_INTERP: state_next = S_SCALE;
      S_SCALE:  state_next = S_FIN;
      S_FIN:    if (fin_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign q_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cell_ok <= '0;
      out_v   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_wr) cell_ok[it.cidx[AW-1:0]] <= 1'b1;
      if (state == S_FIN && fin_go) out_v <= 1'b1;
      else if (res.ready)           out_v <= 1'b0;
    end
  end

  // memory: registered read at item start, write at finish
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      rd_v  <= vmem[q_data.cidx[AW-1:0]];
      rd_t  <= tmem[q_data.cidx[AW-1:0]];
      rd_ok <= cell_ok[q_data.cidx[AW-1:0]] && q_data.in_range;
    end
    if (do_wr) begin
      vmem[it.cidx[AW-1:0]] <= spike ? cfg.reset_v : vsat;
      tmem[it.cidx[AW-1:0]] <= (spike && t_sum[32]) ? 32'hffff_ffff :
                               (spike ? t_sum[31:0] : it.t);
    end
  end

  // datapath, at most one multiply per step, except two in S_MUL1
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_valid) it <= q_data;
      end
      S_MUL1: begin
        cur_v <= rd_ok ? rd_v : 32'sd0;
        t_ok  <= it.t >= last_t;
        x_big <= |xw[47:30];
        x_lo  <= xw[29:0];
        w_neg <= it.w[23];
        pw    <= 47'(w_mag) * 47'(cfg.inv_cap);
      end
      S_MUL2: begin
        y <= yp[60:30];
      end
      S_INTERP: begin
        a_r   <= ta;
        n_r   <= y[30:24];
        dprod <= (32+RW)'(ta - tb) * (32+RW)'(rem);
      end
      S_SCALE: begin
        v_neg <= cur_v[31];
        vprod <= 64'(v_mag) * 64'(fac);
      end
      S_FIN: begin
        if (fin_go) begin
          out_cell <= it.cidx;
          out_t    <= it.t;
          if (!it.in_range) begin
            out_spk  <= 1'b0;
            out_acc  <= 1'b0;
            out_volt <= 32'sd0;
          end else if (!t_ok) begin
            out_spk  <= 1'b0;
            out_acc  <= 1'b0;
            out_volt <= cur_v;
          end else begin
            out_spk  <= spike;
            out_acc  <= 1'b1;
            out_volt <= spike ? cfg.reset_v : vsat;
          end
        end
      end
      default: ;
    endcase
  end

  assign res.valid            = out_v;
  assign res.spiked           = out_spk;
  assign res.accepted         = out_acc;
  assign res.spike_cell       = out_cell;
  assign res.spike_time       = out_t;
  assign res.membrane_voltage = out_volt;

endmodule

FILE: rtl/core/lif_neuron_event_update.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: top level
// Event-driven leaky integrate-and-fire update for a group of cells.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries synaptic events (cell, time, weight); res returns one item
//   per event: spike flag, applied flag, cell, time and the cell's voltage.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle; the block has no check of its own.
// Data flow:
//   The front end registers and classifies an event and a two-item queue
//   decouples it from the back end. The back end works on one item at a
//   time: state read, time-constant and weight multiply, log2(e) multiply,
//   table interpolation, voltage scaling, then sum/compare/write-back; it
//   takes the next item from the queue only after the write-back.
// Reset:
//   Registers return to their defaults and every cell reads as zero voltage
//   and zero update time (per-cell valid bits, cleared at once).
// Stall:
//   While res is stalled the result holds; the back end waits at its final
//   step and the queue and front end fill, then evt.ready drops.
// ----------------------------------------------------------------------------
module lif_neuron_event_update #(
  parameter int NUM_CELLS        = lne_pkg::NUM_CELLS_DEF,
  parameter int DECAY_TABLE_BITS = lne_pkg::DECAY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  lne_pkg::reg_idx_t   cfg_index,
  input  logic [31:0]         cfg_data,
  lne_evt_if.sink             evt,
  lne_res_if.source           res
);
  import lne_pkg::*;

  cfg_t  cfg;
  item_t f_data;
  logic  f_valid;
  logic  f_ready;
  item_t b_data;
  logic  b_valid;
  logic  b_ready;

  // shared cell constants
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_tau   <= 16'd256;
      cfg.inv_cap   <= 24'd65536;
      cfg.threshold <= 32'sd1310720;
      cfg.reset_v   <= 32'sd0;
      cfg.refract   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_TAU:   cfg.inv_tau   <= cfg_data[15:0];
        REG_INV_CAP:   cfg.inv_cap   <= cfg_data[23:0];
        REG_THRESHOLD: cfg.threshold <= cfg_data;
        REG_RESET_V:   cfg.reset_v   <= cfg_data;
        REG_REFRACT:   cfg.refract   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lne_front #(.NUM_CELLS(NUM_CELLS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .q_data  (f_data),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  lne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_data),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (b_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready)
  );

  lne_back #(
    .NUM_CELLS  (NUM_CELLS),
    .DECAY_BITS (DECAY_TABLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_data  (b_data),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .res     (res)
  );

endmodule

FILE: sim/tb_lif_neuron_event_update.sv
// ----------------------------------------------------------------------------
// LIF neuron event update: self-checking testbench
// Drives synaptic events with random gaps and result back-pressure, predicts
// each result from a behavioural model of the cell group and scores every
// returned item in order, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lif_neuron_event_update;
  import lne_pkg::*;

  localparam int N_CELLS   = 64;
  localparam int TBL_BITS  = 8;
  localparam int TBL_SIZE  = (1 << TBL_BITS) + 1;
  localparam int FRAC_SH   = 24 - TBL_BITS;
  localparam logic [63:0] Q31_ONE = 64'd1 << 31;
  localparam int RAND_ITEMS = 170; // per phase, five phases

  typedef struct {
    logic [5:0]         cidx;
    logic [31:0]        t;
    logic signed [23:0] w;
  } event_t;

  typedef struct {
    logic               spiked;
    logic               accepted;
    logic [5:0]         cidx;
    logic [31:0]        t;
    logic signed [31:0] v;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_INV_TAU;
  logic [31:0] cfg_data = 32'd0;

  lne_evt_if evt_ch ();
  lne_res_if res_ch ();

  lif_neuron_event_update dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .res       (res_ch)
  );

  always #1 clk = ~clk;

  // model copy of registers and per-cell state
  logic [15:0]        m_inv_tau;
  logic [23:0]        m_inv_cap;
  logic signed [31:0] m_threshold;
  logic signed [31:0] m_reset_v;
  logic [15:0]        m_refract;
  logic [31:0]        cell_volt [N_CELLS];
  logic [31:0]        cell_last [N_CELLS];
  logic [63:0]        exp2_tbl  [TBL_SIZE];

  event_t   pending_events[$];
  outcome_t expected_results[$];
  logic [31:0] gen_time [N_CELLS];   // stimulus side notion of each cell's clock
  int  error_count = 0;
  bit  quiet = 1'b0;                 // no idling on either side while set

  function automatic logic [63:0] floor_sqrt(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^-(i/256) in Q1.31 from repeated square roots of one half
  task automatic build_exp2_table();
    logic [63:0] roots [TBL_BITS];
    logic [63:0] v;
    logic [63:0] acc;
    v = Q31_ONE >> 1;
    for (int k = 0; k < TBL_BITS; k++) begin
      v = floor_sqrt(v << 31);
      roots[k] = v;
    end
    for (int i = 0; i < TBL_SIZE - 1; i++) begin
      acc = Q31_ONE;
      for (int j = 0; j < TBL_BITS; j++)
        if ((i >> j) & 1) acc = (acc * roots[TBL_BITS - 1 - j] + (64'd1 << 30)) >> 31;
      exp2_tbl[i] = acc;
    end
    exp2_tbl[TBL_SIZE - 1] = Q31_ONE >> 1;
  endtask

  // exp(-elapsed/tau) as Q1.31
  function automatic logic [63:0] leak_factor(logic [31:0] elapsed);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    x = 64'(elapsed) * 64'(m_inv_tau);
    if (x >= (64'd64 << 24)) return 64'd0;
    y = (x * 64'(LOG2E_Q30)) >> 30;
    n = y >> 24;
    f = y & 64'hFF_FFFF;
    a = exp2_tbl[f >> FRAC_SH];
    b = exp2_tbl[(f >> FRAC_SH) + 1];
    d = a - (((a - b) * (f & ((64'd1 << FRAC_SH) - 1))) >> FRAC_SH);
    if (n >= 64'd32) return 64'd0;
    return d >> n;
  endfunction

  // magnitude rounded half away from zero, sign restored
  function automatic longint scale_rounded(longint v, logic [63:0] m, int sh);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    p = (mag * m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic outcome_t integrate_event(event_t e);
    outcome_t o;
    longint   v;
    logic [32:0] t_new;
    o.spiked   = 1'b0;
    o.accepted = 1'b0;
    o.cidx     = e.cidx;
    o.t        = e.t;
    o.v        = cell_volt[e.cidx];
    if (e.t >= cell_last[e.cidx]) begin
      o.accepted = 1'b1;
      t_new = {1'b0, e.t};
      v = scale_rounded(longint'($signed(cell_volt[e.cidx])),
                        leak_factor(e.t - cell_last[e.cidx]), 31);
      v += scale_rounded(longint'(e.w), 64'(m_inv_cap), 16);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (v >= longint'(m_threshold)) begin
        o.spiked = 1'b1;
        t_new = t_new + 33'(m_refract);
        if (t_new[32]) t_new = 33'h0_FFFF_FFFF; // refractory end clips at max time
        o.v = m_reset_v;
      end else begin
        o.v = 32'(v);
      end
      cell_volt[e.cidx] = o.v;
      cell_last[e.cidx] = t_new[31:0];
    end
    return o;
  endfunction

  // known values on every input from time zero
  initial begin
    evt_ch.valid = 1'b0;
    evt_ch.cell_index = '0;
    evt_ch.arrival_time = '0;
    evt_ch.synapse_weight = '0;
    res_ch.ready = 1'b0;
  end

  // event driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      evt_ch.valid <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        e.cidx = evt_ch.cell_index;
        e.t    = evt_ch.arrival_time;
        e.w    = evt_ch.synapse_weight;
        expected_results.insert(expected_results.size(), integrate_event(e));
      end
      if (!evt_ch.valid || evt_ch.ready) begin
        if (pending_events.size() > 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
          e = pending_events.pop_front();
          evt_ch.valid          <= 1'b1;
          evt_ch.cell_index     <= e.cidx;
          evt_ch.arrival_time   <= e.t;
          evt_ch.synapse_weight <= e.w;
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s expected 0x%08h, got 0x%08h", $time, fname, exp_v, act_v);
    end
  endfunction

  // result monitor with random back-pressure
  always @(posedge clk) begin
    outcome_t o;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result item, expected none, got cell %0d time 0x%08h",
                   $time, res_ch.spike_cell, res_ch.spike_time);
        end else begin
          o = expected_results.pop_front();
          check_field("spiked", 32'(o.spiked), 32'(res_ch.spiked));
          check_field("accepted", 32'(o.accepted), 32'(res_ch.accepted));
          check_field("spike_cell", 32'(o.cidx), 32'(res_ch.spike_cell));
          check_field("spike_time", o.t, res_ch.spike_time);
          check_field("membrane_voltage", o.v, res_ch.membrane_voltage);
        end
      end
      res_ch.ready <= quiet || ($urandom_range(0, 99) >= 34);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_INV_TAU:   m_inv_tau   = d[15:0];
      REG_INV_CAP:   m_inv_cap   = d[23:0];
      REG_THRESHOLD: m_threshold = d;
      REG_RESET_V:   m_reset_v   = d;
      REG_REFRACT:   m_refract   = d[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [15:0] tau, logic [23:0] cap, logic [31:0] thr,
                             logic [31:0] rv, logic [15:0] refr);
    write_reg(REG_INV_TAU, 32'(tau));
    write_reg(REG_INV_CAP, 32'(cap));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RESET_V, rv);
    write_reg(REG_REFRACT, 32'(refr));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_event(logic [5:0] c, logic [31:0] t, logic [23:0] w);
    event_t e;
    e.cidx = c;
    e.t    = t;
    e.w    = w;
    pending_events.insert(pending_events.size(), e);
    if (t > gen_time[c]) gen_time[c] = t;
  endtask

  // mostly in-order event trains per cell, some late (refractory) and some noise
  task automatic add_random_events(int count);
    logic [5:0]  c;
    logic [31:0] t;
    logic [23:0] w;
    int          pick;
    for (int i = 0; i < count; i++) begin
      c = 6'($urandom_range(0, N_CELLS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        t = gen_time[c] + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 200000)
                                                     : $urandom_range(0, 300));
        if (t < gen_time[c]) t = 32'hFFFF_FFFF;
      end else if (pick < 90 && gen_time[c] > 0) begin
        t = gen_time[c] - $urandom_range(1, 50);
      end else begin
        t = $urandom;
      end
      if ($urandom_range(0, 3) == 0) w = 24'($urandom);
      else w = 24'($signed($urandom_range(0, 16'hFFFF)) - 32'sd20000);
      add_event(c, t, w);
    end
  endtask

  task automatic drain();
    while (pending_events.size() > 0 || evt_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk); // margin after the last result, before the next phase
  endtask

  initial begin
    m_inv_tau   = 16'd256;
    m_inv_cap   = 24'd65536;
    m_threshold = 32'sd1310720;
    m_reset_v   = 32'sd0;
    m_refract   = 16'd0;
    for (int i = 0; i < N_CELLS; i++) begin
      cell_volt[i] = 32'd0;
      cell_last[i] = 32'd0;
      gen_time[i]  = 32'd0;
    end
    build_exp2_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed items at reset settings: field extremes, decay, late-event drop
    add_event(6'd0, 32'd0, 24'h7F_FFFF);          // large positive weight, spike
    add_event(6'd63, 32'd0, 24'h80_0000);         // most negative weight
    add_event(6'd63, 32'd1, 24'h00_0000);         // zero weight, short decay
    add_event(6'd63, 32'd100000, 24'h00_0001);    // long gap, strong decay
    add_event(6'd5, 32'd10, 24'h0A_0000);         // sub-threshold charge
    add_event(6'd5, 32'd12, 24'h0A_0000);         // stays just below threshold after decay
    add_event(6'd5, 32'd11, 24'h01_0000);         // earlier than last update, dropped
    add_event(6'd7, 32'hFFFF_FFFF, 24'hFF_FFFF);  // max time
    add_event(6'd7, 32'hFFFF_FFFE, 24'h01_0000);  // late, dropped
    add_event(6'd9, 32'hAAAA_5555, 24'h55_AAAA);
    add_event(6'd10, 32'h5555_AAAA, 24'hAA_5555);
    drain();

    // no decay, weights scaled to zero, threshold always met
    load_config(16'd0, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    add_event(6'd20, 32'd500, 24'h12_3456);
    add_event(6'd20, 32'd900, 24'h80_0000);
    add_random_events(RAND_ITEMS);
    drain();

    // strongest settings; refractory end clips at max time
    load_config(16'hFFFF, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    add_event(6'd30, 32'hFFFF_FFF0, 24'h7F_FFFF);
    add_event(6'd30, 32'hFFFF_FFFF, 24'h7F_FFFF);
    add_event(6'd31, 32'd77, 24'h80_0000);
    add_random_events(RAND_ITEMS);
    drain();

    // slow leak, no idling on either side for this stretch
    quiet = 1'b1;
    load_config(16'd1, 24'd65536, 32'sd20 <<< 16, 32'd0, 16'd50);
    add_random_events(RAND_ITEMS);
    drain();
    quiet = 1'b0;

    load_config(16'd300, 24'd40000, 32'sd5 <<< 16, -(32'sd1 <<< 16), 16'd10);
    add_random_events(RAND_ITEMS);
    drain();

    load_config(16'd256, 24'd65536, 32'sd1310720, 32'd0, 16'd3);
    add_random_events(RAND_ITEMS);
    drain();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
